FILE: rtl/lfc_pkg.sv
// shared types and constants for the lru frame cache lookup unit
`default_nettype none

package lfc_pkg;

    localparam int LFC_WAYS        = 8;
    localparam int LFC_SLOT_W      = 6;
    localparam int LFC_KEY_W       = 32;
    localparam int LFC_STAMP_W     = 32;
    localparam int LFC_CFG_W       = 16;
    localparam int LFC_PADDR_W     = 3;
    localparam int LFC_PDATA_W     = 32;

    localparam logic [LFC_CFG_W-1:0]   LFC_SNAP_TOL_RST = 16'd65;
    localparam logic [LFC_PADDR_W-1:0] LFC_ADDR_BASE    = 3'd0;
    localparam logic [LFC_PADDR_W-1:0] LFC_ADDR_SNAP    = 3'd4;

    typedef struct packed {
        logic [LFC_KEY_W-1:0] frame_time;
        logic                 force_req;
    } t_lfc_request;

    typedef struct packed {
        logic                  hit;
        logic [LFC_SLOT_W-1:0] slot;
        logic                  load_needed;
        logic                  evicted_valid;
        logic [LFC_KEY_W-1:0]  evicted_key;
        logic [LFC_CFG_W-1:0]  file_index;
        logic                  needs_blend;
    } t_lfc_result;

    typedef struct packed {
        logic [LFC_KEY_W-1:0]   key;
        logic [LFC_STAMP_W-1:0] stamp;
    } t_lfc_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } t_lfc_state;

endpackage

`default_nettype wire

FILE: rtl/lfc_slot_mem.sv
// slot store: key/stamp memory with registered read and per-slot valid flags
`default_nettype none

module lfc_slot_mem
    import lfc_pkg::*;
#(
    parameter int WAYS = LFC_WAYS,
    localparam int IW  = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rd_en,
    input  wire logic [IW-1:0] i_rd_addr,
    output      t_lfc_entry    o_rd_entry,
    output      logic          o_rd_valid,
    input  wire logic          i_wr_en,
    input  wire logic [IW-1:0] i_wr_addr,
    input  wire t_lfc_entry    i_wr_entry
);

    t_lfc_entry       r_mem [WAYS];
    logic [WAYS-1:0]  r_valid;
    t_lfc_entry       r_rd_entry;
    logic             r_rd_valid;

    // valid flags stand in for the cleared contents after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_entry <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_entry = r_rd_entry;
    assign o_rd_valid = r_rd_valid;

endmodule

`default_nettype wire

FILE: rtl/lru_frame_cache_lookup_unit.sv
// top level of the lru frame cache lookup unit
`default_nettype none

// Fully associative frame cache of WAYS slots with least-recently-used
// replacement by access timestamps. A request is taken when start is high
// and busy is low; the frame time is snapped to a whole frame when its
// fraction lies within snap_tolerance of one, the access clock advances, and
// the slots are read one per cycle from a slot memory with separate read and
// write ports. The scan stops at the first matching valid slot; on a miss
// every slot is read and the first slot with the lowest stamp becomes the
// victim. A write-back state then refreshes the chosen slot, and the result
// is registered from it. busy is high in the scan and write-back states, so
// a new request may be taken in the cycle the result is shown. The result is
// on o_result for exactly one cycle, marked by o_result_valid; the receiver
// cannot stall it.
// Registers (APB, 32-bit data): 0x0 frame_base, 0x4 snap_tolerance.
module lru_frame_cache_lookup_unit
    import lfc_pkg::*;
#(
    parameter int WAYS = LFC_WAYS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // request channel
    input  wire logic                   start,
    output      logic                   busy,
    input  wire t_lfc_request           i_request,
    // result channel
    output      logic                   o_result_valid,
    output      t_lfc_result            o_result,
    // configuration port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [LFC_PADDR_W-1:0] paddr,
    input  wire logic [LFC_PDATA_W-1:0] pwdata,
    output      logic [LFC_PDATA_W-1:0] prdata,
    output      logic                   pready
);

    localparam int IW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [IW:0]   CNT_END  = (IW+1)'(WAYS);
    localparam logic [IW-1:0] LAST_IDX = IW'(WAYS - 1);

    // state machine
    t_lfc_state r_state, n_state;

    // configuration registers
    logic [LFC_CFG_W-1:0] r_frame_base;
    logic [LFC_CFG_W-1:0] r_snap_tol;

    // per-request context
    logic [LFC_KEY_W-1:0]   r_key;
    logic                   r_force;
    logic [LFC_STAMP_W-1:0] r_clock;

    // scan bookkeeping
    logic [IW:0]            r_rd_cnt;
    logic                   r_cmp_vld;
    logic [IW-1:0]          r_cmp_idx;
    logic                   r_hit;
    logic [IW-1:0]          r_hit_idx;
    logic [LFC_STAMP_W-1:0] r_min_stamp;
    logic [IW-1:0]          r_vic_idx;
    logic                   r_vic_valid;
    logic [LFC_KEY_W-1:0]   r_vic_key;

    // result register
    logic        r_res_vld;
    t_lfc_result r_result;

    // memory side
    logic                   rd_en;
    logic [IW-1:0]          rd_addr;
    t_lfc_entry             rd_entry;
    logic                   rd_valid;
    logic                   wr_en;
    logic [IW-1:0]          wr_addr;
    t_lfc_entry             wr_entry;

    logic                   accept;
    logic                   cfg_wr;
    logic [LFC_KEY_W-1:0]   snapped;
    logic [LFC_CFG_W:0]     dist_up;
    logic [LFC_STAMP_W-1:0] cmp_stamp;
    logic                   cmp_hit;
    logic                   cmp_step;
    logic                   cmp_last;
    logic                   load;
    logic                   sel_valid;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    // ------------------------------------------------------------------
    // configuration port: zero wait states, write on the access cycle
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base <= '0;
            r_snap_tol   <= LFC_SNAP_TOL_RST;
        end else if (cfg_wr) begin
            unique case (paddr)
                LFC_ADDR_BASE: r_frame_base <= pwdata[LFC_CFG_W-1:0];
                LFC_ADDR_SNAP: r_snap_tol   <= pwdata[LFC_CFG_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            LFC_ADDR_BASE: prdata = LFC_PDATA_W'(r_frame_base);
            LFC_ADDR_SNAP: prdata = LFC_PDATA_W'(r_snap_tol);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // snap the frame time at acceptance: down when the fraction is under
    // the tolerance, up (wrapping past the top frame) when the distance to
    // the next whole frame is under it
    // ------------------------------------------------------------------
    assign dist_up = (LFC_CFG_W+1)'(17'h10000) - {1'b0, i_request.frame_time[15:0]};

    always_comb begin
        if (i_request.frame_time[15:0] < r_snap_tol) begin
            snapped = {i_request.frame_time[31:16], 16'h0000};
        end else if (dist_up < {1'b0, r_snap_tol}) begin
            snapped = {i_request.frame_time[31:16] + 16'd1, 16'h0000};
        end else begin
            snapped = i_request.frame_time;
        end
    end

    // ------------------------------------------------------------------
    // slot memory: one read per cycle during the scan, one write at the end;
    // the write lands before the next request can start its reads, so no
    // forwarding path is needed
    // ------------------------------------------------------------------
    assign rd_en   = (r_state == ST_SCAN) && (r_rd_cnt < CNT_END);
    assign rd_addr = r_rd_cnt[IW-1:0];

    lfc_slot_mem #(
        .WAYS (WAYS)
    ) u_slot_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_entry (rd_entry),
        .o_rd_valid (rd_valid),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_entry (wr_entry)
    );

    // an empty slot reads with stamp zero, as after reset
    assign cmp_stamp = rd_valid ? rd_entry.stamp : '0;
    assign cmp_hit   = rd_valid && (rd_entry.key == r_key);
    assign cmp_step  = (r_state == ST_SCAN) && r_cmp_vld;
    assign cmp_last  = (r_cmp_idx == LAST_IDX);

    // write-back choice
    assign wr_en          = (r_state == ST_WRITE);
    assign wr_addr        = r_hit ? r_hit_idx : r_vic_idx;
    assign wr_entry.key   = r_key;
    assign wr_entry.stamp = r_clock;

    assign load      = !r_hit || r_force;
    assign sel_valid = r_hit ? 1'b1 : r_vic_valid;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cmp_step && (cmp_hit || cmp_last)) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // access clock and read issue counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock   <= '0;
            r_rd_cnt  <= '0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
        end else begin
            r_cmp_vld <= rd_en;
            if (accept) begin
                r_clock  <= r_clock + 1'b1;
                r_rd_cnt <= '0;
                r_hit    <= 1'b0;
            end else begin
                if (rd_en) begin
                    r_rd_cnt <= r_rd_cnt + 1'b1;
                end
                if (cmp_step && cmp_hit) begin
                    r_hit <= 1'b1;
                end
            end
        end
    end

    // request context and running minimum (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key   <= snapped;
            r_force <= i_request.force_req;
        end
        if (rd_en) begin
            r_cmp_idx <= rd_addr;
        end
        if (cmp_step) begin
            // first slot seeds the minimum, later ones replace it only when
            // strictly lower, so ties keep the earliest slot
            if ((r_cmp_idx == '0) || (cmp_stamp < r_min_stamp)) begin
                r_min_stamp <= cmp_stamp;
                r_vic_idx   <= r_cmp_idx;
                r_vic_valid <= rd_valid;
                r_vic_key   <= rd_entry.key;
            end
            if (cmp_hit) begin
                r_hit_idx <= r_cmp_idx;
            end
        end
    end

    // result formed in the write-back cycle, shown for one cycle after it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= (r_state == ST_WRITE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WRITE) begin
            r_result.hit           <= r_hit;
            r_result.slot          <= LFC_SLOT_W'(wr_addr);
            r_result.load_needed   <= load;
            r_result.evicted_valid <= load && sel_valid;
            // a forced hit evicts its own key
            r_result.evicted_key   <= (load && sel_valid) ? (r_hit ? r_key : r_vic_key) : '0;
            r_result.file_index    <= r_key[31:16] - r_frame_base;
            r_result.needs_blend   <= (r_key[15:0] != 16'h0000);
        end
    end

    assign o_result_valid = r_res_vld;
    assign o_result       = r_result;

endmodule

`default_nettype wire

FILE: rtl/lfc_checker.sv
// port-level checker for the lru frame cache lookup unit, bound to the top level
`default_nettype none

module lfc_checker
    import lfc_pkg::*;
#(
    parameter int WAYS = LFC_WAYS
) (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         start,
    input wire logic         busy,
    input wire logic         o_result_valid,
    input wire t_lfc_result  o_result
);

    // a taken request keeps the unit busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but unit not busy");

    // results are single-cycle strobes and only appear once the unit is free
    a_result_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while busy");

    // a miss always loads, and a plain hit reports no eviction
    a_miss_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.hit) |-> o_result.load_needed)
        else $error("miss without load");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ((int'(o_result.slot) < WAYS) &&
            (o_result.load_needed || (!o_result.evicted_valid &&
            (o_result.evicted_key == '0)))))
        else $error("slot out of range or eviction without load");

endmodule

bind lru_frame_cache_lookup_unit lfc_checker #(
    .WAYS (WAYS)
) u_lfc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

`default_nettype wire
